// ----- hw/rtl/dswr_pkg.sv -----
// shared types and constants for the data stack with roll
`default_nettype none

package dswr_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int WORD_W      = 32;
    localparam int DEPTH_W     = 8;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_ROLL = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [WORD_W-1:0]   push_value;
        logic        [DEPTH_W-1:0]  roll_depth;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]   read_value;
        status_t                    status;
    } out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dswr_in_reg.sv -----
// input register stage of the data stack
`default_nettype none

module dswr_in_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dswr_pkg::in_item_t s_data,
    output logic                    item_valid,
    output dswr_pkg::in_item_t      item_data,
    input  wire logic               item_take
);
    import dswr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    assign s_ready    = !valid_reg || item_take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dswr_stack.sv -----
// top-aligned stack cells with push, pop, peek and roll logic
`default_nettype none

module dswr_stack (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               op_en,
    input  wire dswr_pkg::in_item_t op_item,
    output dswr_pkg::out_item_t     op_result
);
    import dswr_pkg::*;

    localparam int RD_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

    logic [WORD_W-1:0] entry_reg  [STACK_DEPTH];
    logic [WORD_W-1:0] entry_next [STACK_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              empty;
    logic              full;
    logic [RD_W-1:0]   depth_ext;
    logic [RD_W-1:0]   top_ext;
    logic [RD_W-1:0]   depth_clamp;
    logic [IDX_W-1:0]  roll_sel;
    logic              roll_active;
    logic [WORD_W-1:0] moved;

    assign empty       = (count_reg == '0);
    assign full        = (count_reg == CNT_W'(STACK_DEPTH));
    assign depth_ext   = RD_W'(op_item.roll_depth);
    assign top_ext     = RD_W'(count_reg) - RD_W'(1);
    assign depth_clamp = (depth_ext > top_ext) ? top_ext : depth_ext;
    assign roll_sel    = depth_clamp[IDX_W-1:0];
    assign roll_active = (op_item.opcode == OP_ROLL) && !empty && (depth_clamp != '0);
    assign moved       = entry_reg[roll_sel];

    // entry 0 is the top of the stack
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        always_comb begin
            entry_next[g] = entry_reg[g];
            case (op_item.opcode)
                OP_PUSH: begin
                    if (!full) begin
                        if (g == 0) begin
                            entry_next[g] = op_item.push_value;
                        end else begin
                            entry_next[g] = entry_reg[(g > 0) ? g - 1 : 0];
                        end
                    end
                end
                OP_POP: begin
                    if (!empty && (g < STACK_DEPTH - 1)) begin
                        entry_next[g] = entry_reg[(g < STACK_DEPTH - 1) ? g + 1 : g];
                    end
                end
                OP_ROLL: begin
                    if (roll_active) begin
                        if (g == 0) begin
                            entry_next[g] = moved;
                        end else if (IDX_W'(g) <= roll_sel) begin
                            entry_next[g] = entry_reg[(g > 0) ? g - 1 : 0];
                        end
                    end
                end
                default: begin
                    entry_next[g] = entry_reg[g];
                end
            endcase
        end
    end

    always_comb begin
        count_next           = count_reg;
        op_result.read_value = '0;
        op_result.status     = ST_OK;
        case (op_item.opcode)
            OP_PUSH: begin
                if (full) begin
                    op_result.status = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP, OP_PEEK: begin
                if (empty) begin
                    op_result.read_value = EMPTY_WORD;
                    op_result.status     = ST_EMPTY;
                end else begin
                    op_result.read_value = entry_reg[0];
                    if (op_item.opcode == OP_POP) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (op_en) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op_en) begin
            entry_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dswr_out_reg.sv -----
// result register stage of the data stack
`default_nettype none

module dswr_out_reg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                res_valid,
    output logic                     res_ready,
    input  wire dswr_pkg::out_item_t res_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dswr_pkg::out_item_t      m_data
);
    import dswr_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign res_ready  = !valid_reg || m_ready;
    assign valid_next = res_ready ? res_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            data_reg <= res_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/data_stack_with_roll.sv -----
// top level of the data stack with roll
// usage:
//   input channel s_valid / s_ready / s_data carries one opcode transaction:
//   push, pop, peek or roll an entry to the top
//   result channel m_valid / m_ready / m_data returns exactly one result
//   transaction for every input transaction, in order
// the input register holds an accepted transaction, the stack logic computes its
//   result combinationally and the result register captures it when it has room
// throughput: one transaction per cycle while m_ready stays high; the stack update
//   logic sits between the input register and the result register, and every
//   opcode including a roll is computed combinationally between them
// reset: aresetn low at a clock edge empties the stack and drops any
//   transaction in flight; stack words are not cleared, only the count
// stall: while m_ready is low the result register holds, one more
//   transaction is kept in the input register, then s_ready goes low
// empty pop or peek returns all ones with empty status; a push on a full
//   stack is dropped with full status; roll depth past the bottom takes
//   the bottom entry
`default_nettype none

module data_stack_with_roll (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire dswr_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dswr_pkg::out_item_t      m_data
);
    import dswr_pkg::*;

    logic      item_valid;
    in_item_t  item_data;
    logic      res_ready;
    logic      advance;
    out_item_t res_data;

    assign advance = item_valid && res_ready;

    dswr_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item_data  (item_data),
        .item_take  (advance)
    );

    dswr_stack u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_en     (advance),
        .op_item   (item_data),
        .op_result (res_data)
    );

    dswr_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
